// ----- hw/rtl/pssp_pkg.sv -----
// Package for the per-source srTCM policer: state codes, widths and the
// register address map. Depends on nothing.
package pssp_pkg;
    localparam int unsigned TOK_W  = 44;
    localparam int unsigned RATE_W = 24;
    localparam int unsigned TPS_W  = 21;

    typedef enum logic [1:0] {
        REG_CLIENTS = 2'd0,
        REG_ALL     = 2'd1,
        REG_FWD     = 2'd2,
        REG_TPS     = 2'd3
    } t_reg;

    typedef enum logic [3:0] {
        S_IDLE, S_SEARCH, S_SWAIT, S_INSERT, S_FILL,
        S_MRD, S_MWAIT, S_M1, S_M2, S_M3, S_MWR, S_OUT
    } t_state;

    typedef struct packed {
        logic [TOK_W-1:0] tc;
        logic [TOK_W-1:0] te;
        logic [31:0]      last;
    } t_meter;
endpackage

// ----- hw/rtl/pssp_if.sv -----
// Valid/ready channel interfaces for the policer's input and result beats.
// Depends on nothing.
interface pssp_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [31:0] source_addr;
    logic        query_class;
    modport source (output valid, action, source_addr, query_class, input ready);
    modport sink (input valid, action, source_addr, query_class, output ready);
endinterface

interface pssp_out_if;
    logic        valid;
    logic        ready;
    logic        drop;
    logic        report;
    logic [31:0] reported_count;
    logic        table_full;
    modport source (output valid, drop, report, reported_count, table_full, input ready);
    modport sink (input valid, drop, report, reported_count, table_full, output ready);
endinterface

// ----- hw/rtl/pssp_ram.sv -----
// Generic single-port RAM with registered read data.
// Depends on nothing.
module pssp_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// ----- hw/rtl/per_source_srtcm_policer_unit.sv -----
// Top level of the per-source srTCM policer: register port, sequencer and
// the shared add/compare unit. Depends on pssp_pkg, pssp_if, pssp_ram.
//
// A tick beat only advances the time counter, and the block is ready again
// at once. A query beat walks the stored keys through the key memory port,
// in S_SEARCH to address each stored key and in S_SWAIT to compare the
// read word. A hit goes on to one meter check. A missed address is
// inserted and its three meters filled before its check. A query refused
// by a full table goes straight to the result, and so does a query with
// policing off. A drop adds a pass over the report meter. Every result
// beat waits for the receiver. The main bucket sums go through one shared
// adder/comparator, stepped by the sequencer, with further compares and
// subtracts beside it for the overflow split, the clip and the token take.
// The bucket limits for both classes are registered products of rate and
// token scale, and the tokens earned since the last update are a
// registered product too. No clearing pass is needed after reset. The
// result beat is held in an output register until taken.
module per_source_srtcm_policer_unit
    import pssp_pkg::*;
#(
    parameter int unsigned CAPACITY = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    pssp_in_if.sink     in_ch,
    pssp_out_if.source  out_ch
);
    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned MAW = $clog2(CAPACITY * 3);
    // Earned tokens reach 56 bits; with a bucket added the sum needs 57, and the adder is 58 wide.
    localparam int unsigned PROD_W = 32 + RATE_W;
    localparam int unsigned SUM_W = PROD_W + 2;

    logic [8:0]        r_clients;
    logic [RATE_W-1:0] r_all, r_fwd;
    logic [TPS_W-1:0]  r_tps;
    logic [31:0]       r_time;
    logic [CW-1:0]     r_used;

    // Register port: write in the access phase, read any time.
    wire cfg_we = psel && penable && pwrite;
    t_reg reg_sel;
    assign reg_sel = t_reg'(paddr[3:2]);
    assign pready = 1'b1;
    always_comb begin
        unique case (reg_sel)
            REG_CLIENTS: prdata = {23'd0, r_clients};
            REG_ALL:     prdata = {8'd0, r_all};
            REG_FWD:     prdata = {8'd0, r_fwd};
            default:     prdata = {11'd0, r_tps};
        endcase
    end

    // Token scale and bucket limits follow the registers.
    wire [TPS_W-1:0] tps = (r_tps == '0) ? TPS_W'(1) : r_tps;
    logic [TOK_W-1:0] r_cbs_a, r_ebs_a, r_cbs_f, r_ebs_f;
    always_ff @(posedge i_clk) begin
        r_cbs_a <= TOK_W'(r_all * tps);
        r_ebs_a <= TOK_W'((r_all >> 1) * tps);
        r_cbs_f <= TOK_W'(r_fwd * tps);
        r_ebs_f <= TOK_W'((r_fwd >> 1) * tps);
    end

    t_state r_state, n_state;
    logic [31:0]  r_addr;
    logic         r_cls, r_rep;   // r_rep marks the report meter pass
    logic [CW-1:0] r_k;
    logic [AW-1:0] r_slot;
    logic [1:0]   r_fm;
    t_meter       r_m;
    logic [TOK_W-1:0] r_cbs, r_ebs;
    logic [RATE_W-1:0] r_rate;
    logic         r_drop, r_report, r_full;
    logic [31:0]  r_cnt, r_tally;
    logic         r_ovalid;

    // Overflow of the committed bucket, held for the excess step, the excess
    // bucket less the token scale with its compare, and the tokens earned since the meter was last updated.
    logic [SUM_W-1:0]  alu_sum_r;
    logic [TOK_W-1:0]  r_te_dif;
    logic              r_te_ge;
    logic [PROD_W-1:0] r_prod;

    // Key store and drop tally memories.
    logic         key_we;
    logic [AW-1:0] key_a;
    logic [31:0]  key_q, tal_q;
    logic         tal_we;
    logic [31:0]  tal_wd;
    pssp_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_keys (
        .i_clk(i_clk), .i_we(key_we), .i_addr(key_a), .i_wdata(r_addr), .o_rdata(key_q));
    pssp_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_tally (
        .i_clk(i_clk), .i_we(tal_we), .i_addr(r_slot), .i_wdata(tal_wd), .o_rdata(tal_q));

    // Meter memory: one word per meter.
    logic         met_we;
    logic [1:0]   met_m;
    logic [MAW-1:0] met_a;
    t_meter       met_wd, met_q;
    assign met_a = MAW'(r_slot * 3) + MAW'(met_m);
    pssp_ram #(.WIDTH($bits(t_meter)), .DEPTH(CAPACITY * 3)) u_meters (
        .i_clk(i_clk), .i_we(met_we), .i_addr(met_a), .i_wdata(met_wd), .o_rdata(met_q));

    // Elapsed time wraps at 32 bits.
    wire [31:0] elapsed = r_time - met_q.last;

    // Shared adder/comparator: sum = a + b, dif = a - b, ge = (a >= b).
    logic [SUM_W-1:0] alu_a, alu_b, alu_sum, alu_dif;
    logic alu_ge;
    always_comb begin
        alu_sum = alu_a + alu_b;
        alu_dif = alu_a - alu_b;
        alu_ge  = alu_a >= alu_b;
    end

    // Excess bucket after the overflow is added, clipped to its limit.
    wire [TOK_W-1:0] te_clip = (alu_sum > SUM_W'(r_ebs)) ? r_ebs : TOK_W'(alu_sum);

    wire [CW-1:0] limit = ({23'd0, r_clients} > 32'(CAPACITY)) ? CW'(CAPACITY)
                                                               : CW'(r_clients);
    wire in_fire = in_ch.valid && in_ch.ready;
    wire [RATE_W-1:0] cls_rate = in_ch.query_class ? r_fwd : r_all;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (in_fire && in_ch.action) begin
                if (r_clients == '0 || cls_rate == '0) n_state = S_OUT;
                else n_state = S_SEARCH;
            end
            S_SEARCH: n_state = (r_k == r_used) ? S_INSERT : S_SWAIT;
            S_SWAIT:  n_state = (key_q == r_addr) ? S_MRD : S_SEARCH;
            S_INSERT: n_state = (r_used >= limit) ? S_OUT : S_FILL;
            S_FILL:   if (r_fm == 2'd2) n_state = S_MRD;
            S_MRD:    n_state = S_MWAIT;
            S_MWAIT:  n_state = S_M1;
            S_M1:     n_state = S_M2;
            S_M2:     n_state = S_M3;
            S_M3:     n_state = S_MWR;
            S_MWR:    n_state = (r_drop && !r_rep) ? S_MRD : S_OUT;
            S_OUT:    if (out_ch.ready) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        key_we = 1'b0;
        key_a  = AW'(r_k);
        met_we = 1'b0;
        met_m  = r_rep ? 2'd2 : {1'b0, r_cls};
        met_wd = r_m;
        tal_we = 1'b0;
        tal_wd = '0;
        alu_a  = SUM_W'(r_m.tc);
        alu_b  = SUM_W'(r_cbs);
        unique case (r_state)
            S_INSERT: begin
                key_a  = AW'(r_used);
                key_we = (r_used < limit);
                tal_we = key_we;
            end
            S_FILL: begin
                met_we = 1'b1;
                met_m  = r_fm;
                unique case (r_fm)
                    2'd0:    met_wd = '{tc: r_cbs_a, te: r_ebs_a, last: r_time};
                    2'd1:    met_wd = '{tc: r_cbs_f, te: r_ebs_f, last: r_time};
                    default: met_wd = '{tc: TOK_W'(tps), te: '0, last: r_time};
                endcase
            end
            S_M1: begin
                alu_a = SUM_W'(met_q.tc);
                alu_b = SUM_W'(r_prod);
            end
            S_M2: begin
                alu_a = SUM_W'(r_m.te);
                alu_b = alu_sum_r;
            end
            S_M3: begin
                alu_a = SUM_W'(r_m.tc);
                alu_b = SUM_W'(tps);
            end
            S_MWR: begin
                met_we = 1'b1;
                tal_we = !r_rep || r_report;
                tal_wd = r_rep ? 32'd0 : (r_drop ? r_tally + 32'd1 : r_tally);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_clients <= '0;
            r_all     <= '0;
            r_fwd     <= '0;
            r_tps     <= TPS_W'(1000);
            r_time    <= '0;
            r_used    <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_we) begin
                unique case (reg_sel)
                    REG_CLIENTS: r_clients <= pwdata[8:0];
                    REG_ALL:     r_all <= pwdata[RATE_W-1:0];
                    REG_FWD:     r_fwd <= pwdata[RATE_W-1:0];
                    default:     r_tps <= pwdata[TPS_W-1:0];
                endcase
            end
            if (in_fire && !in_ch.action) r_time <= r_time + 32'd1;
            if (r_state == S_INSERT && r_used < limit) r_used <= r_used + CW'(1);
            if (n_state == S_OUT && r_state != S_OUT) r_ovalid <= 1'b1;
            else if (r_state == S_OUT && out_ch.ready) r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_addr   <= in_ch.source_addr;
                r_cls    <= in_ch.query_class;
                r_rep    <= 1'b0;
                r_k      <= '0;
                r_fm     <= '0;
                r_drop   <= 1'b0;
                r_report <= 1'b0;
                r_full   <= 1'b0;
                r_cnt    <= '0;
                r_rate   <= cls_rate;
            end
            S_SEARCH: begin
                // The limits are taken here, once they follow any register
                // write made just before the query.
                r_cbs  <= r_cls ? r_cbs_f : r_cbs_a;
                r_ebs  <= r_cls ? r_ebs_f : r_ebs_a;
                r_slot <= AW'(r_k);
                r_k    <= r_k + CW'(1);
            end
            S_INSERT: begin
                r_slot <= AW'(r_used);
                r_full <= (r_used >= limit);
            end
            S_FILL:  r_fm <= r_fm + 2'd1;
            S_MWAIT: begin
                r_tally <= (r_rep ? r_tally : tal_q);
                r_prod  <= elapsed * r_rate;
            end
            S_M1: begin
                // Add the earned tokens and split any overflow off the
                // committed bucket.
                r_m.last <= r_time;
                r_m.te   <= met_q.te;
                if (alu_sum > SUM_W'(r_cbs)) begin
                    r_m.tc    <= r_cbs;
                    alu_sum_r <= alu_sum - SUM_W'(r_cbs);
                end else begin
                    r_m.tc    <= TOK_W'(alu_sum);
                    alu_sum_r <= '0;
                end
            end
            S_M2: begin
                r_m.te   <= te_clip;
                r_te_dif <= te_clip - TOK_W'(tps);
                r_te_ge  <= te_clip >= TOK_W'(tps);
            end
            S_M3: begin
                if (alu_ge) r_m.tc <= TOK_W'(alu_dif);
                else if (r_te_ge) r_m.te <= r_te_dif;
                if (!r_rep) r_drop <= !alu_ge && !r_te_ge;
                else r_report <= alu_ge || r_te_ge;
            end
            S_MWR: begin
                if (!r_rep && r_drop) begin
                    r_tally <= r_tally + 32'd1;
                    r_rep   <= 1'b1;
                    r_rate  <= RATE_W'(1);
                    r_cbs   <= TOK_W'(tps);
                    r_ebs   <= '0;
                end
                if (r_rep && r_report) r_cnt <= r_tally;
            end
            default: ;
        endcase
    end

    assign in_ch.ready = (r_state == S_IDLE);
    assign out_ch.valid = r_ovalid;
    assign out_ch.drop = r_drop;
    assign out_ch.report = r_report;
    assign out_ch.reported_count = r_cnt;
    assign out_ch.table_full = r_full;
endmodule

// ----- test/tb_pssp_scoreboard.sv -----
// Scoreboard class for the per-source srTCM policer testbench: a bit-true
// predictor of the policing table and a queue of expected result beats.
// Depends on nothing but the simulator.
`timescale 1ns / 1ps

class pssp_policer_sb;
    // Register copies.
    bit [8:0]  clients;
    bit [23:0] rate_all;
    bit [23:0] rate_fwd;
    bit [20:0] tps_reg;
    // Table and meter state.
    bit [31:0] keys [256];
    bit [31:0] tally [256];
    bit [43:0] tok_c [768];
    bit [43:0] tok_e [768];
    bit [31:0] stamp [768];
    int unsigned used;
    bit [31:0] now;
    // Expected result beats: {drop, report, count, full}.
    bit [34:0] pending [$];
    int unsigned errors;
    int unsigned queries, drops, reports, fulls;

    function new();
        clients = 0; rate_all = 0; rate_fwd = 0; tps_reg = 1000;
        used = 0; now = 0; errors = 0;
        queries = 0; drops = 0; reports = 0; fulls = 0;
    endfunction

    function void set_reg(int idx, bit [31:0] v);
        case (idx)
            0: clients = v[8:0];
            1: rate_all = v[23:0];
            2: rate_fwd = v[23:0];
            default: tps_reg = v[20:0];
        endcase
    endfunction

    function bit [63:0] scale();
        return (tps_reg == 0) ? 64'd1 : 64'(tps_reg);
    endfunction

    function bit [63:0] rate_of(int m);
        if (m == 0) return 64'(rate_all);
        if (m == 1) return 64'(rate_fwd);
        return 64'd1;
    endfunction

    // Returns 1 when the meter colours the query red.
    function bit meter_red(int slot, int m);
        bit [63:0] t, r, cbs, ebs, tc, te;
        int i;
        t = scale();
        r = rate_of(m);
        i = slot * 3 + m;
        cbs = (r * t) & 64'hFFF_FFFF_FFFF;
        ebs = ((r / 2) * t) & 64'hFFF_FFFF_FFFF;
        tc = 64'(tok_c[i]) + 64'(32'(now - stamp[i])) * r;
        te = 64'(tok_e[i]);
        stamp[i] = now;
        if (tc > cbs) begin
            te += tc - cbs;
            tc = cbs;
        end
        if (te > ebs) te = ebs;
        meter_red = 0;
        if (tc >= t) tc -= t;
        else if (te >= t) te -= t;
        else meter_red = 1;
        tok_c[i] = tc[43:0];
        tok_e[i] = te[43:0];
    endfunction

    // Called for every accepted input beat.
    function void note_input(bit act, bit [31:0] addr, bit cls);
        int slot, lim, i;
        bit hit;
        bit [63:0] t, r;
        bit [34:0] res;
        if (!act) begin
            now++;
            return;
        end
        queries++;
        res = '0;
        if (clients != 0 && rate_of(cls) != 0) begin
            lim = (clients < 256) ? clients : 256;
            hit = 0; slot = 0;
            for (i = 0; i < used; i++)
                if (!hit && keys[i] == addr) begin
                    hit = 1; slot = i;
                end
            if (!hit && used >= lim) begin
                res[0] = 1;
                fulls++;
            end else begin
                if (!hit) begin
                    slot = used;
                    keys[slot] = addr;
                    tally[slot] = 0;
                    t = scale();
                    for (int m = 0; m < 3; m++) begin
                        r = rate_of(m);
                        tok_c[slot*3+m] = 44'(r * t);
                        tok_e[slot*3+m] = 44'((r / 2) * t);
                        stamp[slot*3+m] = now;
                    end
                    used++;
                end
                if (meter_red(slot, cls)) begin
                    tally[slot]++;
                    res[34] = 1;
                    drops++;
                    if (!meter_red(slot, 2)) begin
                        res[33] = 1;
                        res[32:1] = tally[slot];
                        tally[slot] = 0;
                        reports++;
                    end
                end
            end
        end
        pending.push_back(res);
    endfunction

    // Called for every accepted result beat.
    function void check_result(bit drop, bit rep, bit [31:0] cnt, bit full);
        bit [34:0] e;
        if (pending.size() == 0) begin
            $error("result beat with nothing expected");
            errors++;
            return;
        end
        e = pending.pop_front();
        if (drop != e[34]) begin
            $error("drop: expected %0d, got %0d", e[34], drop); errors++;
        end
        if (rep != e[33]) begin
            $error("report: expected %0d, got %0d", e[33], rep); errors++;
        end
        if (cnt != e[32:1]) begin
            $error("reported_count: expected %0d, got %0d", e[32:1], cnt); errors++;
        end
        if (full != e[0]) begin
            $error("table_full: expected %0d, got %0d", e[0], full); errors++;
        end
    endfunction
endclass

// ----- test/tb_per_source_srtcm_policer_unit.sv -----
// Top level of the policer testbench: clock, reset, APB register writes,
// input and result beat drivers and the run schedule.
// Depends on pssp_pkg, pssp_if, the policer RTL and tb_pssp_scoreboard.
`timescale 1ns / 1ps

module tb_per_source_srtcm_policer_unit;
    import pssp_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    pssp_in_if  in_ch ();
    pssp_out_if out_ch ();

    per_source_srtcm_policer_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_ch(in_ch), .out_ch(out_ch)
    );

    pssp_policer_sb sb = new();

    // Idling controls: percentage of idle cycles on each side, and the
    // long hold-off of the receiver counted in its own process below.
    int unsigned send_idle_pct = 15;
    int unsigned recv_idle_pct = 15;
    int unsigned hold_off = 0;
    longint unsigned cycles = 0;
    // A small pool of addresses so that most queries hit existing entries.
    bit [31:0] addr_pool [16];

    initial begin
        i_clk = 0;
    end
    always begin
        #6 i_clk = 1;
        #6 i_clk = 0;
    end

    // Watchdog: ends the run as failed once the cycle counter passes its limit.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 64'd2_000_000) begin
            $display("tb_per_source_srtcm_policer_unit failed");
            $finish;
        end
    end

    // Result side: sample at the edge, then decide ready for the next one.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            sb.check_result(out_ch.drop, out_ch.report, out_ch.reported_count,
                            out_ch.table_full);
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_off != 0) begin
            hold_off <= hold_off - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Input acceptance is noted in the same edge-sampled style.
    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready)
            sb.note_input(in_ch.action, in_ch.source_addr, in_ch.query_class);
    end

    task automatic reg_write(t_reg idx, bit [31:0] val);
        in_ch.valid <= 0;
        @(posedge i_clk);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= 4'(idx) << 2; pwdata <= val;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        sb.set_reg(int'(idx), val);
    endtask

    // Offers one beat, with a random gap first, and holds it until accepted.
    // Valid stays up after acceptance so that back-to-back beats need no
    // second assignment in the same step; the next gap, drain or register
    // write lowers it.
    task automatic send_beat(bit act, bit [31:0] addr, bit cls);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1; in_ch.action <= act;
        in_ch.source_addr <= addr; in_ch.query_class <= cls;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // Waits for all results, then a little more since ticks give none.
    task automatic drain();
        in_ch.valid <= 0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic random_beats(int n);
        bit [31:0] a;
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(9))
                0, 1, 2, 3: send_beat(0, $urandom, $urandom_range(1));
                4: begin
                    a = $urandom;
                    send_beat(1, a, $urandom_range(1));
                end
                default: send_beat(1, addr_pool[$urandom_range(15)], $urandom_range(1));
            endcase
        end
    endtask

    initial begin
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        in_ch.valid = 0; in_ch.action = 0; in_ch.source_addr = 0;
        in_ch.query_class = 0; out_ch.ready = 0;
        i_rst_n = 0;
        foreach (addr_pool[i]) addr_pool[i] = $urandom;
        addr_pool[0] = 32'h0000_0000;
        addr_pool[1] = 32'hFFFF_FFFF;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;

        // Policing off at reset: every query passes with zero fields.
        send_beat(1, 32'h0A00_0001, 0);
        send_beat(1, 32'hFFFF_FFFF, 1);
        send_beat(0, 32'h0, 0);
        drain();

        // Small table, low rates, a low tick rate so drops come quickly.
        reg_write(REG_CLIENTS, 2);
        reg_write(REG_ALL, 1);
        reg_write(REG_FWD, 0);
        reg_write(REG_TPS, 0);
        send_beat(1, 32'h0000_0000, 1);      // forward class disabled
        for (int k = 0; k < 4; k++) send_beat(1, 32'h0000_0000, 0);
        send_beat(1, 32'hFFFF_FFFF, 0);      // second entry
        send_beat(1, 32'h1234_5678, 0);      // table full
        send_beat(0, 32'hFFFF_FFFF, 1);
        send_beat(0, 32'h0, 0);
        send_beat(1, 32'h0000_0000, 0);
        drain();

        // Shrink the table: existing entries still found, no inserts.
        reg_write(REG_CLIENTS, 1);
        reg_write(REG_FWD, 24'hFFFFFF);
        send_beat(1, 32'hFFFF_FFFF, 1);
        send_beat(1, 32'h5555_AAAA, 1);
        drain();

        // Random phases through several settings, extremes among them.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin reg_write(REG_CLIENTS, 256); reg_write(REG_ALL, 2);
                         reg_write(REG_FWD, 1); reg_write(REG_TPS, 4); end
                1: begin reg_write(REG_ALL, 24'hFFFFFF); reg_write(REG_TPS, 21'h100000); end
                2: begin reg_write(REG_CLIENTS, 8); reg_write(REG_ALL, 3);
                         reg_write(REG_FWD, 5); reg_write(REG_TPS, 21'h1FFFFF); end
                3: begin reg_write(REG_ALL, $urandom_range(1, 20));
                         reg_write(REG_FWD, $urandom_range(1, 20));
                         reg_write(REG_TPS, $urandom_range(1, 16)); end
                4: begin reg_write(REG_CLIENTS, 9'h1FF); reg_write(REG_TPS, 1000); end
                5: begin reg_write(REG_ALL, 1); reg_write(REG_FWD, 1); reg_write(REG_TPS, 2); end
                6: begin reg_write(REG_CLIENTS, 0); end
                default: begin reg_write(REG_CLIENTS, 256); reg_write(REG_ALL, $urandom);
                         reg_write(REG_FWD, $urandom); reg_write(REG_TPS, $urandom); end
            endcase
            if (ph == 1) begin
                send_idle_pct = 0; recv_idle_pct = 0;   // no idling at all
            end else begin
                send_idle_pct = 15; recv_idle_pct = 15;
            end
            if (ph == 2) hold_off = 3000;               // receiver stalls long
            random_beats(140);
            drain();                                    // sender pauses here
        end

        $display("Covered %0d queries: %0d drops, %0d reports, %0d table-full passes.",
                 sb.queries, sb.drops, sb.reports, sb.fulls);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("tb_per_source_srtcm_policer_unit passed");
        end else begin
            $display("tb_per_source_srtcm_policer_unit failed");
        end
        $finish;
    end
endmodule
